@@ hdl/pfi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfi_pkg: shared types and constants of the polyphase fir interpolator
// item layout, mode and register codes, reset values, control groups
// ----------------------------------------------------------------------------
package pfi_pkg;

    // item kinds carried in s_tuser
    typedef enum logic [1:0] {
        MODE_LOAD    = 2'd0,
        MODE_PUSH    = 2'd1,
        MODE_COMPUTE = 2'd2
    } mode_t;

    // configuration register indexes
    localparam logic [1:0] CFG_SIDE_WIDTH = 2'd0;
    localparam logic [1:0] CFG_FRAC_BITS  = 2'd1;
    localparam logic [1:0] CFG_CENTER_LAG = 2'd2;

    localparam int CFG_DATA_W = 15;

    localparam logic [14:0] SIDE_WIDTH_RST = 15'd16384;
    localparam logic [3:0]  FRAC_BITS_RST  = 4'd13;
    localparam logic [5:0]  CENTER_LAG_RST = 6'd2;

    // input tdata layout, lowest bit first
    localparam int COEF_INDEX_W = 14;
    localparam int COEF_VALUE_W = 24;
    localparam int SAMPLE_W     = 24;
    localparam int FRAC_POS_W   = 14;

    localparam int COEF_INDEX_LO = 0;
    localparam int COEF_VALUE_LO = COEF_INDEX_LO + COEF_INDEX_W;
    localparam int SAMPLE_IN_LO  = COEF_VALUE_LO + COEF_VALUE_W;
    localparam int FRAC_POS_LO   = SAMPLE_IN_LO + SAMPLE_W;
    localparam int IN_FIELDS_W   = FRAC_POS_LO + FRAC_POS_W;
    localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;

    localparam int PROD_W = COEF_VALUE_W + SAMPLE_W;
    localparam int ACC_W  = 64;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NEG,
        ST_POS,
        ST_FINISH
    } state_t;

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clr;
        logic tap;
        logic zero;
    } mac_ctrl_t;

endpackage

@@ hdl/pfi_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfi_ram: generic single-port-write, single-port-read memory
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pfi_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/pfi_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfi_mac: multiply-accumulate with rounding and saturation
// registered product, 64-bit accumulator, q19.45 sum rounded to q1.23
// ----------------------------------------------------------------------------
module pfi_mac
    import pfi_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  mac_ctrl_t                      ctrl,
    input  logic signed [COEF_VALUE_W-1:0] coef,
    input  logic signed [SAMPLE_W-1:0]     sample,
    output logic                           busy,
    output logic signed [SAMPLE_W-1:0]     out_sample,
    output logic                           saturated
);

    logic signed [PROD_W-1:0]   prod_reg;
    logic                       prod_valid_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [SAMPLE_W-1:0] sample_eff;
    logic signed [ACC_W-1:0]    rounded;
    logic signed [ACC_W-23:0]   quot;
    logic                       over_hi;
    logic                       over_lo;

    // samples outside the history window count as zero
    assign sample_eff = ctrl.zero ? '0 : sample;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctrl.tap;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= coef * sample_eff;
        if (ctrl.clr)
        begin
            acc_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // add half an lsb then floor, ties go up
    assign rounded = acc_reg + (ACC_W'(1) <<< 21);
    assign quot    = rounded[ACC_W-1:22];
    assign over_hi = quot > (ACC_W-22)'(8388607);
    assign over_lo = quot < -(ACC_W-22)'(8388608);

    always_comb
    begin
        if (over_hi)
        begin
            out_sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        else if (over_lo)
        begin
            out_sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            out_sample = quot[SAMPLE_W-1:0];
        end
    end

    assign saturated = over_hi | over_lo;
    assign busy      = prod_valid_reg;

endmodule

@@ hdl/polyphase_fir_interpolator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphase_fir_interpolator_unit: polyphase fir interpolation engine
// load and push items are written in the cycle they are accepted, while idle
// a compute item walks one tap per cycle, set by the single coefficient read
// port and the one multiplier; its result is loaded when the last product is summed
// and the output is free; the next item is taken in the cycle after the result is loaded
// reset restores register defaults and empties the history; coefficients are kept
// ----------------------------------------------------------------------------
module polyphase_fir_interpolator_unit
    import pfi_pkg::*;
#(
    parameter int COEF_DEPTH    = 16384,
    parameter int HISTORY_DEPTH = 64,
    parameter int FRAC_BITS_MAX = 13
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // coef_index, coef_value, sample_in, frac_pos, zero pad
    input  logic [IN_TDATA_W-1:0] s_tdata,
    // mode
    input  logic [1:0]            s_tuser,
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_sample
    output logic [SAMPLE_W-1:0]   m_tdata,
    // saturated
    output logic                  m_tuser
);

    localparam int CAW = $clog2(COEF_DEPTH);
    localparam int HAW = $clog2(HISTORY_DEPTH);
    localparam int SWW = $clog2(COEF_DEPTH + 1);
    localparam int FBW = FRAC_BITS_MAX + 1;
    localparam int FCW = $clog2(HISTORY_DEPTH + 1);
    localparam int IW  = ((SWW > FBW) ? SWW : FBW) + 1;
    localparam int AGM = (IW > FCW) ? IW : FCW;
    localparam int AGW = ((AGM > 7) ? AGM : 7) + 2;

    state_t state_reg;
    state_t state_next;

    logic [14:0] side_width_reg;
    logic [3:0]  frac_bits_reg;
    logic [5:0]  center_lag_reg;

    logic [HAW-1:0] ptr_reg;
    logic [FCW-1:0] fill_reg;

    logic [IW-1:0]         idx_reg;
    logic [IW-1:0]         pos_idx_reg;
    logic [FBW-1:0]        fsize_reg;
    logic [SWW-1:0]        sw_reg;
    logic signed [AGW-1:0] age_reg;

    logic                rd_tap_reg;
    logic                rd_zero_reg;
    logic                m_tvalid_reg;
    logic [SAMPLE_W-1:0] m_tdata_reg;
    logic                m_tuser_reg;

    // unpacked input fields
    mode_t                   in_mode;
    logic [COEF_INDEX_W-1:0] in_coef_index;
    logic [COEF_VALUE_W-1:0] in_coef_value;
    logic [SAMPLE_W-1:0]     in_sample;
    logic [FRAC_POS_W-1:0]   in_frac_pos;

    logic accept;
    logic start_compute;
    logic do_load;
    logic do_push;
    logic issue;
    logic load_out;
    logic idx_lt_sw;
    logic out_free;
    logic in_window;

    logic [31:0]     sw_clamp;
    logic [3:0]      fb_eff;
    logic [FBW-1:0]  fsize_eff;
    logic [FBW-1:0]  off_eff;
    logic [HAW+1:0]  slot_diff;
    logic [HAW+1:0]  slot_fix;

    mac_ctrl_t                  mac_ctrl;
    logic                       mac_busy;
    logic signed [SAMPLE_W-1:0] mac_out;
    logic                       mac_sat;
    logic [COEF_VALUE_W-1:0]    coef_rdata;
    logic [SAMPLE_W-1:0]        hist_rdata;

    assign in_mode       = mode_t'(s_tuser);
    assign in_coef_index = s_tdata[COEF_INDEX_LO +: COEF_INDEX_W];
    assign in_coef_value = s_tdata[COEF_VALUE_LO +: COEF_VALUE_W];
    assign in_sample     = s_tdata[SAMPLE_IN_LO +: SAMPLE_W];
    assign in_frac_pos   = s_tdata[FRAC_POS_LO +: FRAC_POS_W];

    assign accept = s_tvalid & s_tready;

    always_comb
    begin
        do_load       = 1'b0;
        do_push       = 1'b0;
        start_compute = 1'b0;
        if (accept)
        begin
            unique case (in_mode)
                MODE_LOAD:    do_load = 32'(in_coef_index) < COEF_DEPTH;
                MODE_PUSH:    do_push = 1'b1;
                MODE_COMPUTE: start_compute = 1'b1;
                default:      ;
            endcase
        end
    end

    // effective setup of a compute item
    always_comb
    begin
        if (side_width_reg == '0)
        begin
            sw_clamp = 32'd1;
        end
        else if (32'(side_width_reg) > COEF_DEPTH)
        begin
            sw_clamp = 32'(COEF_DEPTH);
        end
        else
        begin
            sw_clamp = 32'(side_width_reg);
        end
        fb_eff    = (32'(frac_bits_reg) > FRAC_BITS_MAX) ? 4'(FRAC_BITS_MAX)
                                                         : frac_bits_reg;
        fsize_eff = FBW'(1) << fb_eff;
        off_eff   = (32'(in_frac_pos) > 32'(fsize_eff)) ? fsize_eff
                                                        : FBW'(in_frac_pos);
    end

    assign idx_lt_sw = idx_reg < IW'(sw_reg);
    assign out_free  = ~m_tvalid_reg | m_tready;

    // history slot of the current age, valid only inside the window
    assign in_window = (age_reg >= 0) && (age_reg < $signed(AGW'(fill_reg)));
    assign slot_diff = (HAW+2)'(ptr_reg) - (HAW+2)'(1) - age_reg[HAW+1:0];
    assign slot_fix  = slot_diff[HAW+1] ? slot_diff + (HAW+2)'(HISTORY_DEPTH)
                                        : slot_diff;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_compute)
                begin
                    state_next = ST_NEG;
                end
            end
            ST_NEG:
            begin
                if (!idx_lt_sw)
                begin
                    state_next = ST_POS;
                end
            end
            ST_POS:
            begin
                if (!idx_lt_sw)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!rd_tap_reg && !mac_busy && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_NEG:    issue = idx_lt_sw;
            ST_POS:    issue = idx_lt_sw;
            ST_FINISH: load_out = !rd_tap_reg && !mac_busy && out_free;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            side_width_reg <= SIDE_WIDTH_RST;
            frac_bits_reg  <= FRAC_BITS_RST;
            center_lag_reg <= CENTER_LAG_RST;
            ptr_reg        <= '0;
            fill_reg       <= '0;
            rd_tap_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_tap_reg <= issue;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SIDE_WIDTH: side_width_reg <= cfg_data;
                    CFG_FRAC_BITS:  frac_bits_reg  <= cfg_data[3:0];
                    CFG_CENTER_LAG: center_lag_reg <= cfg_data[5:0];
                    default:        ;
                endcase
            end
            if (do_push)
            begin
                ptr_reg <= (32'(ptr_reg) == HISTORY_DEPTH - 1) ? '0 : ptr_reg + HAW'(1);
                if (fill_reg != FCW'(HISTORY_DEPTH))
                begin
                    fill_reg <= fill_reg + FCW'(1);
                end
            end
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // tap walk: coefficient index steps by the phase count, age by one
    always_ff @(posedge clk)
    begin
        rd_zero_reg <= ~in_window;
        if (start_compute)
        begin
            sw_reg      <= SWW'(sw_clamp);
            fsize_reg   <= fsize_eff;
            idx_reg     <= IW'(off_eff);
            pos_idx_reg <= IW'(fsize_eff - off_eff);
            age_reg     <= AGW'(center_lag_reg);
        end
        else if (state_reg == ST_NEG)
        begin
            if (idx_lt_sw)
            begin
                idx_reg <= idx_reg + IW'(fsize_reg);
                age_reg <= age_reg + AGW'(1);
            end
            else
            begin
                idx_reg <= pos_idx_reg;
                age_reg <= AGW'(center_lag_reg) - AGW'(1);
            end
        end
        else if (state_reg == ST_POS && idx_lt_sw)
        begin
            idx_reg <= idx_reg + IW'(fsize_reg);
            age_reg <= age_reg - AGW'(1);
        end
        if (load_out)
        begin
            m_tdata_reg <= mac_out;
            m_tuser_reg <= mac_sat;
        end
    end

    pfi_ram #(
        .WIDTH(COEF_VALUE_W),
        .DEPTH(COEF_DEPTH)
    ) u_coef_ram (
        .clk  (clk),
        .we   (do_load),
        .waddr(CAW'(in_coef_index)),
        .wdata(in_coef_value),
        .raddr(idx_reg[CAW-1:0]),
        .rdata(coef_rdata)
    );

    pfi_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(HISTORY_DEPTH)
    ) u_hist_ram (
        .clk  (clk),
        .we   (do_push),
        .waddr(ptr_reg),
        .wdata(in_sample),
        .raddr(slot_fix[HAW-1:0]),
        .rdata(hist_rdata)
    );

    assign mac_ctrl.clr  = start_compute;
    assign mac_ctrl.tap  = rd_tap_reg;
    assign mac_ctrl.zero = rd_zero_reg;

    pfi_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mac_ctrl),
        .coef      ($signed(coef_rdata)),
        .sample    ($signed(hist_rdata)),
        .busy      (mac_busy),
        .out_sample(mac_out),
        .saturated (mac_sat)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
